// File: hw/rtl/fflpool_pkg.sv
// Shared widths, codes and controller/datapath interface types for the frame pool.
`timescale 1ns / 1ps

package fflpool_pkg;

    localparam int IDX_W    = 5;
    localparam int SIZE_W   = 6;
    localparam int LINK_W   = 6;
    localparam int STATUS_W = 2;

    // Link value that marks the end of the free list (and an empty list).
    localparam logic [LINK_W-1:0] LINK_END = 6'd63;

    localparam logic KIND_GET     = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    typedef struct packed {
        logic load_cfg;
        logic sweep;
        logic capture;
        logic get_read;
        logic get_update;
        logic rel_clear;
        logic rel_link;
        logic finish_empty;
        logic finish_range;
    } dp_cmd_t;

    typedef struct packed {
        logic is_release;
        logic head_ok;
        logic in_range;
        logic sweep_last;
    } dp_sts_t;

endpackage

// File: hw/rtl/fifo_free_list_frame_pool.sv
// Top level of the frame pool with a FIFO free list held as a linked array.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------
//  request  | start in, busy out        | kind, frame_index
//  result   | done out, one-cycle pulse | granted, slot, status
//  config   | cfg_valid in, cfg_ready out | pool_size
//
// A failed request (empty pool, release out of range) ends in DECIDE; a granted get
// and an in-range release end in GET_UPD or REL_LINK. Each step makes one access to
// the single-port link memory, and a release writes two links (one into an empty
// list). A new request may start in the done cycle. A pool size write rebuilds the
// links in a sweep over every slot while busy is high. Reset empties the pool
// without a sweep; results cannot be stalled.
`timescale 1ns / 1ps

module fifo_free_list_frame_pool #(
    parameter int POOL_DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             kind,
    input  logic [fflpool_pkg::IDX_W-1:0]    frame_index,
    output logic                             done,
    output logic                             granted,
    output logic [fflpool_pkg::IDX_W-1:0]    slot,
    output logic [fflpool_pkg::STATUS_W-1:0] status,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fflpool_pkg::SIZE_W-1:0]   pool_size
);

    fflpool_pkg::dp_cmd_t cmd;
    fflpool_pkg::dp_sts_t sts;

    fflpool_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .done      (done)
    );

    fflpool_datapath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (kind),
        .frame_index (frame_index),
        .pool_size   (pool_size),
        .granted     (granted),
        .slot        (slot),
        .status      (status)
    );

`ifndef NO_ASSERTIONS
    a_done_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while the block is busy");

    a_start_sets_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither busy nor finished");

    a_cfg_sets_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (busy && !done))
        else $error("pool size write did not start the rebuild");

    a_granted_ok : assert property (@(posedge clk) disable iff (!rst_n)
        (done && granted) |-> (status == fflpool_pkg::STATUS_OK))
        else $error("granted slot with a failure status");
`endif

endmodule

// File: hw/rtl/fflpool_datapath.sv
// Datapath of the frame pool: link memory, head and tail pointers, result registers.
`timescale 1ns / 1ps

module fflpool_datapath #(
    parameter int POOL_DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  fflpool_pkg::dp_cmd_t             cmd,
    output fflpool_pkg::dp_sts_t             sts,
    input  logic                             kind,
    input  logic [fflpool_pkg::IDX_W-1:0]    frame_index,
    input  logic [fflpool_pkg::SIZE_W-1:0]   pool_size,
    output logic                             granted,
    output logic [fflpool_pkg::IDX_W-1:0]    slot,
    output logic [fflpool_pkg::STATUS_W-1:0] status
);

    localparam int ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam logic [fflpool_pkg::SIZE_W-1:0] DEPTH_SIZE = fflpool_pkg::SIZE_W'(POOL_DEPTH);
    localparam logic [fflpool_pkg::LINK_W-1:0] DEPTH_LINK = fflpool_pkg::LINK_W'(POOL_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_DEPTH - 1);

    logic [fflpool_pkg::LINK_W-1:0]   link_mem [POOL_DEPTH];

    logic [fflpool_pkg::SIZE_W-1:0]   size_reg;
    logic [fflpool_pkg::LINK_W-1:0]   head_reg;
    logic [fflpool_pkg::LINK_W-1:0]   tail_reg;
    logic [ADDR_W-1:0]                cnt_reg;
    logic                             kind_reg;
    logic [fflpool_pkg::IDX_W-1:0]    idx_reg;
    logic [fflpool_pkg::LINK_W-1:0]   rdata_reg;
    logic                             granted_reg;
    logic [fflpool_pkg::IDX_W-1:0]    slot_reg;
    logic [fflpool_pkg::STATUS_W-1:0] status_reg;

    logic [fflpool_pkg::SIZE_W-1:0]   size_sat;
    logic [fflpool_pkg::LINK_W-1:0]   idx_link;
    logic [fflpool_pkg::LINK_W-1:0]   cnt_inc;
    logic [fflpool_pkg::LINK_W-1:0]   sweep_val;
    logic                             tail_ok;
    logic                             wr_en;
    logic [ADDR_W-1:0]                wr_addr;
    logic [fflpool_pkg::LINK_W-1:0]   wr_data;

    always_comb
    begin
        size_sat  = (pool_size > DEPTH_SIZE) ? DEPTH_SIZE : pool_size;
        idx_link  = fflpool_pkg::LINK_W'(idx_reg);
        cnt_inc   = fflpool_pkg::LINK_W'(cnt_reg) + 1'b1;
        // The rebuilt chain links each slot to the next; the last slot ends the list.
        sweep_val = (cnt_inc < size_reg) ? cnt_inc : fflpool_pkg::LINK_END;
        tail_ok   = (tail_reg < DEPTH_LINK);

        sts.is_release = (kind_reg == fflpool_pkg::KIND_RELEASE);
        sts.head_ok    = (head_reg < DEPTH_LINK);
        sts.in_range   = (fflpool_pkg::SIZE_W'(idx_reg) < size_reg);
        sts.sweep_last = (cnt_reg == LAST_ADDR);
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        priority if (cmd.sweep)
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg;
            wr_data = sweep_val;
        end
        else if (cmd.rel_clear)
        begin
            wr_en   = 1'b1;
            wr_addr = idx_link[ADDR_W-1:0];
            wr_data = fflpool_pkg::LINK_END;
        end
        else if (cmd.rel_link && tail_ok)
        begin
            wr_en   = 1'b1;
            wr_addr = tail_reg[ADDR_W-1:0];
            wr_data = idx_link;
        end
        else
        begin
            wr_en   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (cmd.get_read)
        begin
            rdata_reg <= link_mem[head_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
            head_reg <= fflpool_pkg::LINK_END;
            tail_reg <= fflpool_pkg::LINK_END;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.load_cfg)
            begin
                size_reg <= size_sat;
                cnt_reg  <= '0;
                if (size_sat == '0)
                begin
                    head_reg <= fflpool_pkg::LINK_END;
                    tail_reg <= fflpool_pkg::LINK_END;
                end
                else
                begin
                    head_reg <= '0;
                    tail_reg <= size_sat - 1'b1;
                end
            end
            if (cmd.sweep && !sts.sweep_last)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.get_update)
            begin
                head_reg <= rdata_reg;
                if (rdata_reg == fflpool_pkg::LINK_END)
                begin
                    tail_reg <= fflpool_pkg::LINK_END;
                end
            end
            if (cmd.rel_link)
            begin
                // An empty list takes the released slot as its only entry.
                if (!tail_ok)
                begin
                    head_reg <= idx_link;
                end
                tail_reg <= idx_link;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            idx_reg  <= frame_index;
        end
        if (cmd.finish_empty)
        begin
            granted_reg <= 1'b0;
            slot_reg    <= '0;
            status_reg  <= fflpool_pkg::STATUS_EMPTY;
        end
        if (cmd.finish_range)
        begin
            granted_reg <= 1'b0;
            slot_reg    <= '0;
            status_reg  <= fflpool_pkg::STATUS_RANGE;
        end
        if (cmd.get_update)
        begin
            granted_reg <= 1'b1;
            slot_reg    <= head_reg[fflpool_pkg::IDX_W-1:0];
            status_reg  <= fflpool_pkg::STATUS_OK;
        end
        if (cmd.rel_link)
        begin
            granted_reg <= 1'b0;
            slot_reg    <= '0;
            status_reg  <= fflpool_pkg::STATUS_OK;
        end
    end

    assign granted = granted_reg;
    assign slot    = slot_reg;
    assign status  = status_reg;

endmodule

// File: hw/rtl/fflpool_ctrl.sv
// Controller state machine of the frame pool: sequences requests and list rebuilds.
`timescale 1ns / 1ps

module fflpool_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 cfg_valid,
    input  fflpool_pkg::dp_sts_t sts,
    output fflpool_pkg::dp_cmd_t cmd,
    output logic                 busy,
    output logic                 cfg_ready,
    output logic                 done
);

    typedef enum logic [2:0] {
        IDLE,
        SWEEP,
        DECIDE,
        GET_UPD,
        REL_LINK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done_next  = 1'b0;
        unique case (state_reg)
            IDLE:
            begin
                // A request wins over a configuration write in the same cycle.
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = DECIDE;
                end
                else if (cfg_valid)
                begin
                    cmd.load_cfg = 1'b1;
                    state_next   = SWEEP;
                end
            end
            SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = IDLE;
                end
            end
            DECIDE:
            begin
                if (!sts.is_release)
                begin
                    if (sts.head_ok)
                    begin
                        cmd.get_read = 1'b1;
                        state_next   = GET_UPD;
                    end
                    else
                    begin
                        cmd.finish_empty = 1'b1;
                        done_next        = 1'b1;
                        state_next       = IDLE;
                    end
                end
                else if (sts.in_range)
                begin
                    cmd.rel_clear = 1'b1;
                    state_next    = REL_LINK;
                end
                else
                begin
                    cmd.finish_range = 1'b1;
                    done_next        = 1'b1;
                    state_next       = IDLE;
                end
            end
            GET_UPD:
            begin
                cmd.get_update = 1'b1;
                done_next      = 1'b1;
                state_next     = IDLE;
            end
            REL_LINK:
            begin
                cmd.rel_link = 1'b1;
                done_next    = 1'b1;
                state_next   = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != IDLE);
            done_reg  <= done_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign cfg_ready = (state_reg == IDLE) && !start;

endmodule
